// File: hw/rtl/rmr_pkg.sv
package rmr_pkg;

  // Default ring geometry.
  localparam int SLOTS_DEF   = 8;
  localparam int MAX_LEN_DEF = 32;

  // Fixed port field widths.
  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int MLEN_W   = 8;
  localparam int INDEX_W  = 8;
  localparam int OSLOT_W  = 3;
  localparam int OLEN_W   = 5;

  // Operation codes carried on the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_STORE = 2'd0,
    MODE_SEND  = 2'd1,
    MODE_FREE  = 2'd2
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;    // store one message byte
    logic free;     // clear one slot length
    logic start;    // begin sending the slot under the send pointer
    logic read;     // fetch the current byte from the byte store
    logic step;     // move to the next byte of the message
    logic advance;  // move the send pointer to the next slot
  } rmr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;  // slot under the send pointer is empty
    logic last;      // current byte is the final byte of the message
  } rmr_stat_t;

endpackage

// File: hw/rtl/rmr_ram.sv
module rmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/rmr_ctrl.sv
module rmr_ctrl import rmr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] mode,
  output logic              out_valid,
  input  logic              out_stall,
  input  rmr_stat_t         stat,
  output rmr_cmd_t          cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_STORE: cmd.store = 1'b1;
            MODE_SEND: begin
              if (stat.len_zero) begin
                cmd.advance = 1'b1;
              end else begin
                cmd.start  = 1'b1;
                state_next = ST_READ;
              end
            end
            MODE_FREE: cmd.free = 1'b1;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (stat.last) begin
            cmd.advance = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            cmd.step   = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

endmodule

// File: hw/rtl/rmr_dp.sv
module rmr_dp import rmr_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  rmr_cmd_t           cmd,
  output rmr_stat_t          stat,
  input  logic [MLEN_W-1:0]  msg_length,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic [INDEX_W-1:0] slot_index,
  output logic [OSLOT_W-1:0] out_slot,
  output logic [OLEN_W-1:0]  out_length,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW    = $clog2(MAX_LEN);
  localparam int DEPTH = SLOTS * MAX_LEN;
  localparam int AW    = $clog2(DEPTH);

  logic [SW-1:0] write_slot;
  logic [SW-1:0] send_slot;
  logic [LW-1:0] byte_counter;
  logic [LW-1:0] send_idx;
  logic [LW-1:0] slot_lengths [SLOTS];

  logic [SW-1:0] write_slot_inc;
  logic [SW-1:0] send_slot_inc;
  logic [LW-1:0] cur_len;
  logic          len_ok;
  logic          len_empty;
  logic          msg_done;
  logic          free_ok;
  logic          ram_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign write_slot_inc = (write_slot == SW'(SLOTS - 1)) ? '0 : write_slot + SW'(1);
  assign send_slot_inc  = (send_slot == SW'(SLOTS - 1)) ? '0 : send_slot + SW'(1);

  assign cur_len   = slot_lengths[send_slot];
  assign len_ok    = (msg_length < MLEN_W'(MAX_LEN));
  assign len_empty = (msg_length == '0);
  assign msg_done  = ((9'(byte_counter) + 9'd1) >= 9'(msg_length));
  assign free_ok   = (slot_index < INDEX_W'(SLOTS));

  assign ram_we  = cmd.store && len_ok && !len_empty;
  assign wr_addr = AW'(write_slot) * AW'(MAX_LEN) + AW'(byte_counter);
  assign rd_addr = AW'(send_slot) * AW'(MAX_LEN) + AW'(send_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      send_slot    <= '0;
      byte_counter <= '0;
      send_idx     <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_lengths[i] <= '0;
      end
    end else begin
      if (cmd.store && len_ok) begin
        if (len_empty || msg_done) begin
          slot_lengths[write_slot] <= LW'(msg_length);
          send_slot                <= write_slot;
          write_slot               <= write_slot_inc;
          byte_counter             <= '0;
        end else begin
          byte_counter <= byte_counter + LW'(1);
        end
      end
      if (cmd.free && free_ok) begin
        slot_lengths[slot_index[SW-1:0]] <= '0;
      end
      if (cmd.start) begin
        send_idx <= '0;
      end
      if (cmd.step) begin
        send_idx <= send_idx + LW'(1);
      end
      if (cmd.advance) begin
        send_slot <= send_slot_inc;
      end
    end
  end

  rmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_bytes (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr),
    .wr_data (in_byte),
    .rd_en   (cmd.read),
    .rd_addr (rd_addr),
    .rd_data (out_byte)
  );

  assign stat.len_zero = (cur_len == '0);
  assign stat.last     = ((send_idx + LW'(1)) == cur_len);

  assign out_slot   = OSLOT_W'(send_slot);
  assign out_length = OLEN_W'(cur_len);
  assign out_last   = stat.last;

endmodule

// File: hw/rtl/retransmit_message_ring.sv
// Channel   Direction  Handshake            Fields
// input     in         in_valid / in_stall  mode, msg_length, in_byte, slot_index
// output    out        out_valid/out_stall  out_slot, out_length, out_byte, out_last
//
// A store or free word, or a send tick on an empty slot, is accepted and completed in the idle state.
// A send tick on a nonempty slot is accepted in the idle state; then, for each byte, the
// read state does the registered read of the byte store and the out state shows it.
// Synchronous reset clears the slot lengths and all pointers; the byte store is not
// cleared. The input is stalled for the whole of a send, and a stalled output word holds.
module retransmit_message_ring import rmr_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  mode,
  input  logic [MLEN_W-1:0]  msg_length,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic [INDEX_W-1:0] slot_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OSLOT_W-1:0] out_slot,
  output logic [OLEN_W-1:0]  out_length,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last
);

  // Commands and status between the sequencer and the datapath.
  rmr_cmd_t  cmd;
  rmr_stat_t stat;

  // The controller accepts a word only while idle, and walks through the
  // bytes of a message one read and one output handshake at a time.
  rmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the slot pointers, the byte counter of the message
  // being stored, the slot lengths and the byte store itself.
  rmr_dp #(
    .SLOTS   (SLOTS),
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .msg_length (msg_length),
    .in_byte    (in_byte),
    .slot_index (slot_index),
    .out_slot   (out_slot),
    .out_length (out_length),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

// File: hw/rtl/rmr_checker.sv
module rmr_checker import rmr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [OSLOT_W-1:0] out_slot,
  input logic [OLEN_W-1:0]  out_length,
  input logic [BYTE_W-1:0]  out_byte,
  input logic               out_last
);

  // No output word may be pending right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  // A stalled output word keeps its byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled output word changed");

  // New input is held off while a message is being sent.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input accepted during a send");

  // Only nonempty messages are sent.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> out_length != '0)
    else $error("word sent from an empty slot");

  // Within one message the slot and length do not change between bytes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_last |=> $stable(out_slot) && $stable(out_length))
    else $error("slot or length changed inside a message");

endmodule

bind retransmit_message_ring rmr_checker u_rmr_checker (.*);
